// ----- hw/rtl/etok_pkg.sv -----
// Shared types and codes for the expression tokenizer.
// Holds transfer payload structs, token kind codes and the run mode enum.
// No dependencies.
package etok_pkg;

    localparam logic [3:0] KIND_END     = 4'd0;
    localparam logic [3:0] KIND_EQ      = 4'd1;
    localparam logic [3:0] KIND_PLUS    = 4'd2;
    localparam logic [3:0] KIND_MUL     = 4'd3;
    localparam logic [3:0] KIND_SEMI    = 4'd4;
    localparam logic [3:0] KIND_LPAREN  = 4'd5;
    localparam logic [3:0] KIND_RPAREN  = 4'd6;
    localparam logic [3:0] KIND_INT     = 4'd7;
    localparam logic [3:0] KIND_ID      = 4'd8;
    localparam logic [3:0] KIND_UNKNOWN = 4'd9;

    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MUL    = 8'h2A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_UNDER  = 8'h5F;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        MODE_IDLE = 3'b001,
        MODE_INT  = 3'b010,
        MODE_ID   = 3'b100
    } mode_t;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       end_of_input;
    } in_t;

    typedef struct packed {
        logic [3:0] token_kind;
        logic [7:0] text_byte;
        logic       text_valid;
        logic       token_done;
        logic       last;
    } out_t;

    typedef struct packed {
        out_t       first;
        out_t       second;
        logic [1:0] count;
        mode_t      next_mode;
    } step_t;

endpackage

// ----- hw/rtl/etok_classify.sv -----
// Character classifier and run mode step for the expression tokenizer.
// Maps one input byte and the current run mode to up to two results.
// Depends on etok_pkg.
module etok_classify (
    input  etok_pkg::in_t   item,
    input  etok_pkg::mode_t mode,
    output etok_pkg::step_t step
);
    import etok_pkg::*;

    logic       eoi;
    logic       is_digit;
    logic       is_alpha;
    logic       is_space;
    logic       is_open;
    logic       has_tok;
    logic [3:0] open_kind;
    logic [3:0] op_kind;
    logic       is_op;
    out_t       close_res;
    out_t       tok_res;
    mode_t      tok_mode;

    assign eoi = item.end_of_input || (item.byte_value == 8'd0);
    assign is_digit = (item.byte_value >= 8'h30) && (item.byte_value <= 8'h39);
    assign is_alpha = ((item.byte_value >= 8'h61) && (item.byte_value <= 8'h7A))
                   || ((item.byte_value >= 8'h41) && (item.byte_value <= 8'h5A));
    assign is_space = (item.byte_value == 8'h20)
                   || ((item.byte_value >= 8'd9) && (item.byte_value <= 8'd13));
    assign is_open = (mode == MODE_INT) || (mode == MODE_ID);
    assign open_kind = (mode == MODE_INT) ? KIND_INT : KIND_ID;
    assign close_res = '{token_kind: open_kind, text_byte: 8'd0, text_valid: 1'b0,
                         token_done: 1'b1, last: 1'b0};

    always_comb
    begin
        is_op = 1'b1;
        case (item.byte_value)
            CH_EQ:     op_kind = KIND_EQ;
            CH_PLUS:   op_kind = KIND_PLUS;
            CH_MUL:    op_kind = KIND_MUL;
            CH_SEMI:   op_kind = KIND_SEMI;
            CH_LPAREN: op_kind = KIND_LPAREN;
            CH_RPAREN: op_kind = KIND_RPAREN;
            default:
            begin
                op_kind = KIND_UNKNOWN;
                is_op   = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        tok_res  = '{token_kind: KIND_UNKNOWN, text_byte: 8'd0, text_valid: 1'b0,
                     token_done: 1'b1, last: 1'b1};
        tok_mode = MODE_IDLE;
        has_tok  = 1'b1;
        if (is_space)
        begin
            has_tok = 1'b0;
        end
        else if (is_op)
        begin
            tok_res.token_kind = op_kind;
        end
        else if (is_digit)
        begin
            tok_res  = '{token_kind: KIND_INT, text_byte: item.byte_value,
                         text_valid: 1'b1, token_done: 1'b0, last: 1'b1};
            tok_mode = MODE_INT;
        end
        else if (is_alpha || (item.byte_value == CH_UNDER))
        begin
            tok_res  = '{token_kind: KIND_ID, text_byte: item.byte_value,
                         text_valid: 1'b1, token_done: 1'b0, last: 1'b1};
            tok_mode = MODE_ID;
        end
    end

    always_comb
    begin
        step.first     = close_res;
        step.second    = tok_res;
        step.count     = 2'd0;
        step.next_mode = MODE_IDLE;
        if (eoi)
        begin
            step.second = '{token_kind: KIND_END, text_byte: 8'd0, text_valid: 1'b0,
                            token_done: 1'b1, last: 1'b1};
            if (is_open)
            begin
                step.count = 2'd2;
            end
            else
            begin
                step.first = step.second;
                step.count = 2'd1;
            end
        end
        else if (((mode == MODE_INT) && is_digit)
              || ((mode == MODE_ID) && (is_alpha || is_digit
                                        || (item.byte_value == CH_UNDER))))
        begin
            step.first = '{token_kind: open_kind, text_byte: item.byte_value,
                           text_valid: 1'b1, token_done: 1'b0, last: 1'b1};
            step.count     = 2'd1;
            step.next_mode = mode;
        end
        else
        begin
            step.next_mode = tok_mode;
            if (is_open)
            begin
                if (has_tok)
                begin
                    step.count = 2'd2;
                end
                else
                begin
                    step.first.last = 1'b1;
                    step.count      = 2'd1;
                end
            end
            else if (has_tok)
            begin
                step.first = tok_res;
                step.count = 2'd1;
            end
        end
    end

endmodule

// ----- hw/rtl/etok_outq.sv -----
// Result queue for the expression tokenizer.
// Takes up to two results per cycle and hands out one per transfer.
// Depends on etok_pkg.
module etok_outq (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [1:0]              push_count,
    input  etok_pkg::out_t          push_first,
    input  etok_pkg::out_t          push_second,
    output logic                    room,
    output logic                    token_valid,
    input  logic                    token_stall,
    output etok_pkg::out_t          token_item
);
    import etok_pkg::*;

    out_t               slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  head_reg;
    logic [QPTR_W-1:0]  head_next;
    logic [QPTR_W-1:0]  tail_reg;
    logic [QPTR_W-1:0]  tail_next;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;
    logic               pop;

    assign token_valid = (count_reg != '0);
    assign token_item  = slot_reg[head_reg];
    assign room        = (count_reg <= QCNT_W'(QUEUE_DEPTH - 2));
    assign pop         = token_valid && !token_stall;

    assign head_next  = head_reg + QPTR_W'(pop);
    assign tail_next  = tail_reg + QPTR_W'(push_count);
    assign count_next = count_reg + QCNT_W'(push_count) - QCNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            slot_reg[tail_reg] <= push_first;
        end
        if (push_count == 2'd2)
        begin
            slot_reg[tail_reg + QPTR_W'(1)] <= push_second;
        end
    end

endmodule

// ----- hw/rtl/expression_tokenizer_core.sv -----
// Top level of the expression tokenizer.
// Ties the run mode register, the classifier and the result queue together.
// Depends on etok_pkg, etok_classify and etok_outq.
//
// Usage:
//   Source bytes enter on the byte channel (byte_valid, byte_stall,
//   byte_item); token results leave on the token channel (token_valid,
//   token_stall, token_item). A transfer happens when valid is high and
//   stall is low at a rising clock edge.
//   A byte is classified in the cycle it is taken; its results are written
//   to the result queue, which offers them in order. One byte per cycle is
//   taken while the queue has room and each byte gives at most one result;
//   a byte that closes an open token and starts its own gives two.
//   The four-entry result queue sets the limit: byte_stall rises while the
//   queue holds more than two results, so a stalled receiver backs up into
//   the byte channel without losing a result.
//   Reset clears the run mode (no open token) and empties the queue.
module expression_tokenizer_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           byte_valid,
    output logic           byte_stall,
    input  etok_pkg::in_t  byte_item,
    output logic           token_valid,
    input  logic           token_stall,
    output etok_pkg::out_t token_item
);
    import etok_pkg::*;

    mode_t      mode_reg;
    mode_t      mode_next;
    step_t      step;
    logic       room;
    logic       accept;
    logic [1:0] push_count;

    assign byte_stall = !room;
    assign accept     = byte_valid && room;
    assign push_count = accept ? step.count : 2'd0;
    assign mode_next  = accept ? step.next_mode : mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    etok_classify u_classify (
        .item (byte_item),
        .mode (mode_reg),
        .step (step)
    );

    etok_outq u_outq (
        .clk         (clk),
        .rst_n       (rst_n),
        .push_count  (push_count),
        .push_first  (step.first),
        .push_second (step.second),
        .room        (room),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .token_item  (token_item)
    );

endmodule

// ----- hw/rtl/etok_checker.sv -----
// Port-level checks for the expression tokenizer.
// Watches the top level's channels and is bound to expression_tokenizer_core.
// Depends on etok_pkg.
module etok_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           byte_valid,
    input logic           byte_stall,
    input etok_pkg::in_t  byte_item,
    input logic           token_valid,
    input logic           token_stall,
    input etok_pkg::out_t token_item
);
    import etok_pkg::*;

    a_byte_hold: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && byte_stall |=> byte_valid && $stable(byte_item))
        else $error("byte payload changed while stalled");

    a_token_hold: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && token_stall |=> token_valid && $stable(token_item))
        else $error("token payload changed while stalled");

    a_stall_backs_up: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> token_valid)
        else $error("byte channel stalled with no result pending");

    a_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && (token_item.token_kind == KIND_END)
        |-> token_item.last && token_item.token_done && !token_item.text_valid)
        else $error("end token not final");

    a_text_kind: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && token_item.text_valid
        |-> !token_item.token_done && token_item.last
            && ((token_item.token_kind == KIND_INT) || (token_item.token_kind == KIND_ID)))
        else $error("text on a token kind without text");

endmodule

bind expression_tokenizer_core etok_checker u_etok_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_valid  (byte_valid),
    .byte_stall  (byte_stall),
    .byte_item   (byte_item),
    .token_valid (token_valid),
    .token_stall (token_stall),
    .token_item  (token_item)
);
